@@ rtl/ggn_pkg.sv @@
// Shared constants, types and command structs of the grid neighbor enumerator.
`default_nettype none

package ggn_pkg;

  localparam int unsigned IDX_BITS     = 64;
  localparam int unsigned COORD_BITS   = 29;
  localparam int unsigned RES_BITS     = 6;
  localparam int unsigned RADIUS_BITS  = 2;
  localparam int unsigned MAX_RING_DEF = 3;

  // Offsets cover -MAX_RING..MAX_RING for every ring size up to three.
  localparam int unsigned OFF_BITS = 4;

  // The step is STEP_NUM / 2^res micro-degrees; the shift saturates at SHIFT_CAP.
  localparam int unsigned STEP_NUM  = 93750;
  localparam int unsigned SHIFT_CAP = 20;
  localparam int unsigned E_BITS    = 5;
  localparam int unsigned WIDE      = COORD_BITS + SHIFT_CAP;

  localparam logic [COORD_BITS-1:0] LAT_SPAN = COORD_BITS'(180000000);
  localparam logic [COORD_BITS-1:0] LON_SPAN = COORD_BITS'(360000000);

  typedef struct packed {
    logic                       load;
    logic                       issue;
    logic                       last;
    logic signed [OFF_BITS-1:0] dlat;
    logic signed [OFF_BITS-1:0] dlon;
  } ggn_cmd_t;

  typedef struct packed {
    logic advance;
  } ggn_sts_t;

endpackage

`default_nettype wire

@@ rtl/ggn_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface ggn_in_if;
  logic                               valid;
  logic                               ready;
  logic [ggn_pkg::IDX_BITS-1:0]       cell_index;
  logic [ggn_pkg::RADIUS_BITS-1:0]    ring_radius;

  modport source (output valid, output cell_index, output ring_radius, input ready);
  modport sink   (input valid, input cell_index, input ring_radius, output ready);
endinterface

interface ggn_out_if;
  logic                         valid;
  logic                         ready;
  logic [ggn_pkg::IDX_BITS-1:0] neighbor_index;
  logic                         last_neighbor;

  modport source (output valid, output neighbor_index, output last_neighbor, input ready);
  modport sink   (input valid, input neighbor_index, input last_neighbor, output ready);
endinterface

`default_nettype wire

@@ rtl/ggn_ctrl.sv @@
// Controller: run state machine and the latitude/longitude offset scan counters.
`default_nettype none

module ggn_ctrl #(
  parameter int unsigned MAX_RING = ggn_pkg::MAX_RING_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [ggn_pkg::RADIUS_BITS-1:0] ring_radius_i,
  output      logic                            in_ready_o,
  input  wire ggn_pkg::ggn_sts_t               sts_i,
  output      ggn_pkg::ggn_cmd_t               cmd_o
);
  import ggn_pkg::*;

  localparam int unsigned CNT_W = $clog2(2 * MAX_RING + 1);
  localparam logic [RADIUS_BITS-1:0] RING_TOP = RADIUS_BITS'(MAX_RING);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       lat_cnt_q, lat_cnt_d;
  logic [CNT_W-1:0]       lon_cnt_q, lon_cnt_d;
  logic [RADIUS_BITS-1:0] radius_q, radius_d;
  logic [RADIUS_BITS-1:0] radius_sat;
  logic [CNT_W-1:0]       cnt_mid;
  logic [CNT_W-1:0]       cnt_end;
  logic [OFF_BITS-1:0]    radius_ext;
  logic                   accept;
  logic                   lat_at_end;
  logic                   lon_at_end;

  assign radius_sat = (ring_radius_i > RING_TOP) ? RING_TOP : ring_radius_i;
  assign cnt_mid    = CNT_W'(radius_q);
  assign cnt_end    = CNT_W'({radius_q, 1'b0});
  assign radius_ext = OFF_BITS'(radius_q);
  assign lat_at_end = (lat_cnt_q == cnt_end);
  assign lon_at_end = (lon_cnt_q == cnt_end);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.issue = (state_q == ST_RUN) && !((lat_cnt_q == cnt_mid) && (lon_cnt_q == cnt_mid));
    cmd_o.last  = (state_q == ST_RUN) && lat_at_end && lon_at_end;
    cmd_o.dlat  = $signed(OFF_BITS'(lat_cnt_q) - radius_ext);
    cmd_o.dlon  = $signed(OFF_BITS'(lon_cnt_q) - radius_ext);
  end

  always_comb begin
    state_d   = state_q;
    lat_cnt_d = lat_cnt_q;
    lon_cnt_d = lon_cnt_q;
    radius_d  = radius_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          radius_d  = radius_sat;
          lat_cnt_d = '0;
          lon_cnt_d = '0;
          if (radius_sat != '0) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // The scan only moves when the pipeline can take the next position.
        if (sts_i.advance) begin
          if (lon_at_end) begin
            lon_cnt_d = '0;
            if (lat_at_end) begin
              lat_cnt_d = '0;
              state_d   = ST_IDLE;
            end else begin
              lat_cnt_d = lat_cnt_q + 1'b1;
            end
          end else begin
            lon_cnt_d = lon_cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lat_cnt_q <= '0;
      lon_cnt_q <= '0;
      radius_q  <= '0;
    end else begin
      state_q   <= state_d;
      lat_cnt_q <= lat_cnt_d;
      lon_cnt_q <= lon_cnt_d;
      radius_q  <= radius_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ggn_datapath.sv @@
// Datapath: held center, offset add with clamp, rounding stage and result register.
`default_nettype none

module ggn_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ggn_pkg::IDX_BITS-1:0] cell_index_i,
  input  wire ggn_pkg::ggn_cmd_t            cmd_i,
  output      ggn_pkg::ggn_sts_t            sts_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [ggn_pkg::IDX_BITS-1:0] neighbor_index_o,
  output      logic                         last_neighbor_o
);
  import ggn_pkg::*;

  localparam logic signed [18:0] STEP_S = 19'(STEP_NUM);

  // Sum in units of 2^-e micro-degree, clamped to zero and to span << e.
  function automatic logic [WIDE-1:0] clamp_sum(
    input logic [COORD_BITS-1:0]      raw,
    input logic signed [OFF_BITS-1:0] off,
    input logic [E_BITS-1:0]          e,
    input logic [COORD_BITS-1:0]      span
  );
    logic [WIDE-1:0]          base_u;
    logic [WIDE-1:0]          hi_u;
    logic signed [WIDE+1:0]   step;
    logic signed [WIDE+1:0]   sum;
    logic [WIDE-1:0]          res;
    base_u = WIDE'(raw) << e;
    hi_u   = WIDE'(span) << e;
    step   = off * STEP_S;
    sum    = $signed({2'b00, base_u}) + step;
    if (sum < 0) begin
      res = '0;
    end else if (sum > $signed({2'b00, hi_u})) begin
      res = hi_u;
    end else begin
      res = sum[WIDE-1:0];
    end
    return res;
  endfunction

  // Round half up and drop the e fraction bits.
  function automatic logic [COORD_BITS-1:0] round_down(
    input logic [WIDE-1:0]   val,
    input logic [E_BITS-1:0] e
  );
    logic [WIDE:0] biased;
    logic [WIDE:0] shifted;
    biased  = (WIDE+1)'(val) + ((WIDE+1)'(1) << (e - 1'b1));
    shifted = biased >> e;
    return (e == '0) ? val[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
  endfunction

  logic [RES_BITS-1:0]   res_q;
  logic [COORD_BITS-1:0] lat_q;
  logic [COORD_BITS-1:0] lon_q;
  logic [E_BITS-1:0]     e_now;

  logic                  s1_valid_q;
  logic                  s1_last_q;
  logic [RES_BITS-1:0]   s1_res_q;
  logic [E_BITS-1:0]     s1_e_q;
  logic [WIDE-1:0]       s1_lat_q;
  logic [WIDE-1:0]       s1_lon_q;

  logic                  out_valid_q;
  logic                  out_last_q;
  logic [IDX_BITS-1:0]   out_index_q;
  logic                  advance;

  // The whole pipeline moves when the result register is empty or being taken.
  assign advance       = !out_valid_q || out_ready_i;
  assign sts_o.advance = advance;

  assign e_now = (res_q > RES_BITS'(SHIFT_CAP)) ? E_BITS'(SHIFT_CAP) : res_q[E_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= cell_index_i[IDX_BITS-1 -: RES_BITS];
      lat_q <= cell_index_i[2*COORD_BITS-1 -: COORD_BITS];
      lon_q <= cell_index_i[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= cmd_i.issue;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q   <= cmd_i.last;
      s1_res_q    <= res_q;
      s1_e_q      <= e_now;
      s1_lat_q    <= clamp_sum(lat_q, cmd_i.dlat, e_now, LAT_SPAN);
      s1_lon_q    <= clamp_sum(lon_q, cmd_i.dlon, e_now, LON_SPAN);
      out_last_q  <= s1_last_q;
      out_index_q <= {s1_res_q, round_down(s1_lat_q, s1_e_q), round_down(s1_lon_q, s1_e_q)};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neighbor_index_o = out_index_q;
  assign last_neighbor_o  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/geo_grid_neighbor_enumerator.sv @@
// Top level of the grid neighbor enumerator: controller, datapath and checks.
//
//   Channel  Dir  Beat contents
//   in_if    in   cell_index (64), ring_radius (2)
//   out_if   out  neighbor_index (64), last_neighbor (1)
//
// An input with radius k yields (2k+1)^2 - 1 neighbors, one per cycle while the output is
// not stalled; the scan walks all (2k+1)^2 positions and the skipped center leaves one bubble.
// Each position passes an add-with-clamp stage and a rounding stage, and the next input is
// taken once the scan has walked its last position and the controller is idle again.
// Reset is asynchronous; the block comes up idle and ready.
// A stalled result stalls the whole pipeline and the scan in place.
`default_nettype none

module geo_grid_neighbor_enumerator #(
  parameter int unsigned MAX_RING = ggn_pkg::MAX_RING_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ggn_in_if.sink    in_if,
  ggn_out_if.source out_if
);
  import ggn_pkg::*;

  ggn_cmd_t cmd;
  ggn_sts_t sts;

  ggn_ctrl #(
    .MAX_RING (MAX_RING)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .ring_radius_i (in_if.ring_radius),
    .in_ready_o    (in_if.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ggn_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cell_index_i     (in_if.cell_index),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .neighbor_index_o (out_if.neighbor_index),
    .last_neighbor_o  (out_if.last_neighbor)
  );

`ifndef SYNTHESIS
  a_busy_after_run_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && (in_if.ring_radius != '0)) |=> !in_if.ready)
    else $error("input taken again right after a run started");

  a_issue_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !in_if.ready)
    else $error("neighbor issued while idle");

  a_last_is_issued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.last |-> cmd.issue)
    else $error("last marker on a skipped position");

  a_scan_holds_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sts.advance && !cmd.load) |=> ($stable(cmd.dlat) && $stable(cmd.dlon)))
    else $error("scan moved while the pipeline was stalled");
`endif

endmodule

`default_nettype wire
